### design/csv_field_tokenizer_unit_assert.svh
// Assertion macros shared by the checker of the CSV field tokenizer.
`ifndef CSV_FIELD_TOKENIZER_UNIT_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cft assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cft assertion failed");

`endif

### design/cft_pkg.sv
// Types, constants and helper functions of the CSV field tokenizer.
package cft_pkg;

	localparam logic [15:0] QUOTE_CH = 16'h0022;
	localparam logic [15:0] COMMA_CH = 16'h002C;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_EOL  = 1'b1;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_END  = 1'b1
	} op_e_t;

	// Work handed from the front end to the back end.
	typedef struct packed {
		op_e_t       code;
		logic        is_space;
		logic        done;
		logic [15:0] ch;
	} op_t;

	// One result transaction.
	typedef struct packed {
		logic        kind;
		logic [15:0] out_char;
		logic        line_done;
		logic        space_overflow;
		logic        last_of_run;
	} res_t;

	function automatic logic is_space16(input logic [15:0] c);
		logic r;
		r = 1'b0;
		if (c >= 16'h0009 && c <= 16'h000D) r = 1'b1;
		if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) r = 1'b1;
		if (c >= 16'h2000 && c <= 16'h200A) r = 1'b1;
		if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) r = 1'b1;
		if (c == 16'h205F || c == 16'h3000) r = 1'b1;
		return r;
	endfunction

endpackage

### design/cft_fifo.sv
// Small register queue used between front and back end and at the result side.
module cft_fifo #(
	parameter type T = logic [0:0],
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  T                           din,
	input  logic                       pop,
	output T                           dout,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] cnt
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign cnt     = cnt_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/cft_front.sv
// Front end: quote tracking and classification of each accepted item.
module cft_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           cmd,
	input  logic [15:0]    ch,
	output logic           op_valid,
	output cft_pkg::op_t   op
);

	logic in_quotes_q;
	logic quote_pending_q;
	logic in_quotes_d;
	logic quote_pending_d;

	always_comb begin
		logic handled;
		handled         = 1'b0;
		in_quotes_d     = in_quotes_q;
		quote_pending_d = quote_pending_q;
		op_valid        = 1'b0;
		op.code         = cft_pkg::OP_CHAR;
		op.is_space     = cft_pkg::is_space16(ch);
		op.done         = 1'b0;
		op.ch           = ch;
		if (cmd == cft_pkg::CMD_EOL) begin
			in_quotes_d     = 1'b0;
			quote_pending_d = 1'b0;
			op_valid        = 1'b1;
			op.code         = cft_pkg::OP_END;
			op.done         = 1'b1;
		end else begin
			if (quote_pending_q) begin
				quote_pending_d = 1'b0;
				if (ch == cft_pkg::QUOTE_CH) begin
					// A doubled quote inside quotes stands for one literal quote.
					op_valid = 1'b1;
					handled  = 1'b1;
				end else begin
					in_quotes_d = 1'b0;
				end
			end
			if (!handled) begin
				if (ch == cft_pkg::QUOTE_CH) begin
					if (in_quotes_d) begin
						quote_pending_d = 1'b1;
					end else begin
						in_quotes_d = 1'b1;
					end
				end else if (ch == cft_pkg::COMMA_CH && !in_quotes_d) begin
					op_valid = 1'b1;
					op.code  = cft_pkg::OP_END;
				end else begin
					op_valid = 1'b1;
				end
			end
		end
		op_valid = op_valid && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q     <= 1'b0;
			quote_pending_q <= 1'b0;
		end else if (accept) begin
			in_quotes_q     <= in_quotes_d;
			quote_pending_q <= quote_pending_d;
		end
	end

endmodule

### design/cft_back.sv
// Back end: field trimming, held whitespace memory and result generation.
module cft_back #(
	parameter int MAX_HELD_SPACES = 16,
	parameter int OUT_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_avail,
	input  cft_pkg::op_t                   op,
	output logic                           op_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt,
	output logic                           res_valid,
	output cft_pkg::res_t                  res
);

	localparam int IW = (MAX_HELD_SPACES > 1) ? $clog2(MAX_HELD_SPACES) : 1;
	localparam int CW = $clog2(MAX_HELD_SPACES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_CHAR
	} state_t;

	state_t         state_q;
	logic           field_started_q;
	logic [CW-1:0]  held_count_q;
	logic           overflow_q;
	logic [IW-1:0]  rd_idx_q;

	logic [15:0]    held_mem [MAX_HELD_SPACES];
	logic [15:0]    rdata_q;

	logic           v_s1;
	logic           mem_s1;
	cft_pkg::res_t  res_s1;

	logic           credit;
	logic           mem_we;
	logic           rd_en;
	logic           last_rd;
	logic           emit_end;
	logic           emit_char;

	assign credit  = (int'(out_cnt) + int'(v_s1)) < OUT_DEPTH;
	assign last_rd = ({1'b0, rd_idx_q} + 1'b1) == (IW + 1)'(held_count_q);

	always_comb begin
		op_pop    = 1'b0;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		emit_end  = 1'b0;
		emit_char = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_avail) begin
					if (op.code == cft_pkg::OP_END) begin
						emit_end = credit;
						op_pop   = credit;
					end else if (op.is_space) begin
						op_pop = 1'b1;
						mem_we = field_started_q && (held_count_q < CW'(MAX_HELD_SPACES));
					end else if (held_count_q == '0) begin
						emit_char = credit;
						op_pop    = credit;
					end
				end
			end
			ST_FLUSH: begin
				rd_en = credit;
			end
			ST_CHAR: begin
				emit_char = credit;
				op_pop    = credit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			held_mem[held_count_q[IW-1:0]] <= op.ch;
		end
		if (rd_en) begin
			rdata_q <= held_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			field_started_q <= 1'b0;
			held_count_q    <= '0;
			overflow_q      <= 1'b0;
			rd_idx_q        <= '0;
			v_s1            <= 1'b0;
			mem_s1          <= 1'b0;
			res_s1          <= '0;
		end else begin
			v_s1   <= emit_end || emit_char || rd_en;
			mem_s1 <= rd_en;
			if (emit_end) begin
				res_s1.kind           <= cft_pkg::KIND_END;
				res_s1.out_char       <= '0;
				res_s1.line_done      <= op.done;
				res_s1.space_overflow <= overflow_q;
				res_s1.last_of_run    <= 1'b1;
				field_started_q       <= 1'b0;
				held_count_q          <= '0;
				overflow_q            <= 1'b0;
			end else if (emit_char) begin
				res_s1.kind           <= cft_pkg::KIND_CHAR;
				res_s1.out_char       <= op.ch;
				res_s1.line_done      <= 1'b0;
				res_s1.space_overflow <= 1'b0;
				res_s1.last_of_run    <= 1'b1;
				field_started_q       <= 1'b1;
				held_count_q          <= '0;
				state_q               <= ST_IDLE;
			end else if (rd_en) begin
				res_s1.kind           <= cft_pkg::KIND_CHAR;
				res_s1.out_char       <= '0;
				res_s1.line_done      <= 1'b0;
				res_s1.space_overflow <= 1'b0;
				res_s1.last_of_run    <= 1'b0;
				rd_idx_q              <= rd_idx_q + 1'b1;
				if (last_rd) begin
					state_q <= ST_CHAR;
				end
			end else if (state_q == ST_IDLE && op_avail && op.code == cft_pkg::OP_CHAR) begin
				if (op.is_space) begin
					if (mem_we) begin
						held_count_q <= held_count_q + 1'b1;
					end else if (field_started_q) begin
						overflow_q <= 1'b1;
					end
				end else if (held_count_q != '0) begin
					// Held whitespace turned out to be inner: replay it first.
					rd_idx_q <= '0;
					state_q  <= ST_FLUSH;
				end
			end
		end
	end

	assign res_valid = v_s1;

	always_comb begin
		res = res_s1;
		if (mem_s1) begin
			res.out_char = rdata_q;
		end
	end

endmodule

### design/csv_field_tokenizer_unit.sv
// CSV field tokenizer: takes one UTF-16 code unit or an end-of-line command per
// push and returns field characters and end-of-field marks, with RFC 4180 quote
// handling and trimming of whitespace at both ends of every field. When idle, the
// back end takes a whitespace item without condition and any other item that
// yields at most one result once the result queue has room; a non-space character
// that follows held whitespace occupies the back end while it is seen, while the
// held characters are replayed from the hold memory one entry per cycle over its
// single read port whenever the result queue has room, and while it is emitted.
// A two-entry work queue lets the input keep running during such a replay, and a
// four-entry result queue absorbs stalls on pop. Characters held beyond
// MAX_HELD_SPACES are dropped and flagged on the field's end mark. There is no clearing pass after reset.
module csv_field_tokenizer_unit #(
	parameter int MAX_HELD_SPACES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [15:0] ch,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [15:0] out_char,
	output logic        line_done,
	output logic        space_overflow,
	output logic        last_of_run
);

	localparam int OP_DEPTH  = 2;
	localparam int OUT_DEPTH = 4;

	logic                           accept;
	logic                           fe_valid;
	cft_pkg::op_t                   fe_op;
	cft_pkg::op_t                   be_op;
	logic                           opq_empty;
	logic                           be_pop;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt;
	logic                           res_valid;
	cft_pkg::res_t                  res;
	cft_pkg::res_t                  head;

	assign accept = push && !full;

	cft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.ch       (ch),
		.op_valid (fe_valid),
		.op       (fe_op)
	);

	cft_fifo #(
		.T     (cft_pkg::op_t),
		.DEPTH (OP_DEPTH)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_valid),
		.din    (fe_op),
		.pop    (be_pop),
		.dout   (be_op),
		.full   (full),
		.empty  (opq_empty),
		.cnt    ()
	);

	cft_back #(
		.MAX_HELD_SPACES (MAX_HELD_SPACES),
		.OUT_DEPTH       (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_avail  (!opq_empty),
		.op        (be_op),
		.op_pop    (be_pop),
		.out_cnt   (out_cnt),
		.res_valid (res_valid),
		.res       (res)
	);

	cft_fifo #(
		.T     (cft_pkg::res_t),
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.pop    (pop),
		.dout   (head),
		.full   (),
		.empty  (empty),
		.cnt    (out_cnt)
	);

	assign kind           = head.kind;
	assign out_char       = head.out_char;
	assign line_done      = head.line_done;
	assign space_overflow = head.space_overflow;
	assign last_of_run    = head.last_of_run;

endmodule

### design/cft_checker.sv
// Port-level checker of the CSV field tokenizer and its bind.
`include "csv_field_tokenizer_unit_assert.svh"

module cft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [15:0] out_char,
	input logic        line_done,
	input logic        space_overflow,
	input logic        last_of_run
);

	// An end-of-field mark carries no character.
	`CFT_ASSERT_NOW(a_end_no_char, !empty && kind == cft_pkg::KIND_END, out_char == '0)
	// Line and overflow flags belong to end-of-field marks only.
	`CFT_ASSERT_NOW(a_char_no_flags, !empty && kind == cft_pkg::KIND_CHAR, !line_done && !space_overflow)
	// The end of a line always closes the run of its input item.
	`CFT_ASSERT_NOW(a_line_done_last, !empty && line_done, last_of_run && kind == cft_pkg::KIND_END)
	// A result that is not taken stays on the ports.
	`CFT_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_char) && $stable(kind))

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.kind           (kind),
	.out_char       (out_char),
	.line_done      (line_done),
	.space_overflow (space_overflow),
	.last_of_run    (last_of_run)
);
